FILE: sv/assert_macros.svh
// Assertion macros shared by the card shuffle cipher RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define CHK_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: sv/csc_pkg.sv
// Package for the card shuffle stream cipher: item kinds, sequencer states, widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;
    localparam int unsigned TDATA_W = 32;

    typedef enum logic [2:0] {
        KIND_KEY     = 3'd0,
        KIND_SETUP   = 3'd1,
        KIND_ENCRYPT = 3'd2,
        KIND_DECRYPT = 3'd3,
        KIND_HASH    = 3'd4,
        KIND_CLEAR   = 3'd5,
        KIND_NONE6   = 3'd6,
        KIND_NONE7   = 3'd7
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_FILL,       // deck sweep write (identity, inverse, zero)
        ST_KEYWR,
        ST_DR_RD,      // draw: read deck[run]
        ST_DR_KEY,     // draw: key read
        ST_DR_CHK,
        ST_SW_RDI,
        ST_SW_RDS,
        ST_SW_WRI,
        ST_SW_WRS,
        ST_SD_1, ST_SD_3, ST_SD_5, ST_SD_7, ST_SD_R, ST_SD_DONE,
        ST_M_ROT,      // read deck[rotor]
        ST_M_PC, ST_M_RA, ST_M_PP, ST_M_RO,
        ST_M_W1, ST_M_W2, ST_M_W3, ST_M_W4,
        ST_M_T,        // deck[t]
        ST_M_AV,       // deck[aval]
        ST_M_RO2,      // deck[rotor]
        ST_M_A,        // deck[av+ro]
        ST_M_X1, ST_M_X2, ST_M_X3, // deck[pp],deck[pc],deck[ra]
        ST_M_B1, ST_M_B2,
        ST_M_FIN,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: sv/card_shuffle_stream_cipher_top.sv
// Top level of the card shuffle stream cipher: sequencer around one deck port.
// Depends on csc_pkg, csc_deck_ram, assert_macros.svh.
//
//  channel | dir | tdata bits (low first)                           | tuser     | tlast
//  s_      | in  | data_in[7:0] key_index[15:8] key_length[23:16]   | kind[2:0] |  -
//          |     | hash_length[30:24] pad[31]                       |           |
//  m_      | out | data_out[7:0]                                    |  -        | last
//
// Encrypt/decrypt: 14 dependent deck reads on the single port, 4 writes, finish and
// output. Keyed setup falls back to repeated subtraction for a draw past 11 retries.
// Reset: synchronous, active low; the RAMs are not reset, so reset and clear run a zero
// sweep of deck and key store (ready low).
// Stalls: a result waits in the output register; input is not ready while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module card_shuffle_stream_cipher_top #(
    parameter int unsigned MAX_HASH_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // data_in, key_index, key_length, hash_length, pad
    input  wire logic [csc_pkg::TDATA_W-1:0] s_tdata,
    input  wire logic [2:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // data_out
    output logic             m_tlast
);
    localparam int unsigned HW = 7;

    csc_pkg::state_t state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] din_reg, din_next, kidx_reg, kidx_next, klen_reg, klen_next;
    logic [HW-1:0] hcnt_reg, hcnt_next;
    logic       hphase_reg, hphase_next; // 1: hash output phase
    logic [8:0] cnt_reg, cnt_next;   // fill addr / swap index / hash mix count
    logic [1:0] fmode_reg, fmode_next; // 0 zero,1 ident,2 inverse
    logic [7:0] rot_reg, rot_next, rat_reg, rat_next, av_reg, av_next;
    logic [7:0] pp_reg, pp_next, pc_reg, pc_next;
    logic [7:0] run_reg, run_next, pos_reg, pos_next, m_reg, m_next;
    logic [3:0] tries_reg, tries_next;
    logic [7:0] sel_reg, sel_next, t_reg, t_next, u_reg, u_next;
    logic [7:0] x_reg, x_next, a_reg, a_next, b_reg, b_next;
    logic [7:0] ct_reg, ct_next, pt_reg, pt_next;
    logic       rd_reg, rd_next; // deck read data valid (also the subtract loop flag)
    logic       ov_reg, ov_next;
    logic [7:0] od_reg, od_next;
    logic       ol_reg, ol_next;

    logic [7:0] key_mem [256];
    logic [7:0] key_rd;
    logic       key_we;
    logic [7:0] key_waddr, key_wdata;

    logic       ram_we;
    logic [7:0] ram_addr, ram_wdata, ram_rdata;

    csc_deck_ram u_deck (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata (ram_wdata), .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd <= key_mem[pos_reg];
    end

    // capped hash length
    logic [HW-1:0] hlen_in;
    always_comb begin
        hlen_in = s_tdata[30:24];
        if (hlen_in > HW'(MAX_HASH_BYTES)) begin
            hlen_in = HW'(MAX_HASH_BYTES);
        end
    end

    logic [7:0] draw_v;
    logic [7:0] top8;
    logic [7:0] mod_v;

    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg; din_next = din_reg; kidx_next = kidx_reg;
        klen_next = klen_reg; hcnt_next = hcnt_reg; hphase_next = hphase_reg;
        cnt_next = cnt_reg; fmode_next = fmode_reg;
        rot_next = rot_reg; rat_next = rat_reg; av_next = av_reg;
        pp_next = pp_reg; pc_next = pc_reg; run_next = run_reg;
        pos_next = pos_reg; m_next = m_reg; tries_next = tries_reg;
        sel_next = sel_reg; t_next = t_reg; u_next = u_reg; x_next = x_reg;
        a_next = a_reg; b_next = b_reg; ct_next = ct_reg; pt_next = pt_reg;
        rd_next = 1'b0; ov_next = ov_reg; od_next = od_reg; ol_next = ol_reg;
        ram_we = 1'b0; ram_addr = 8'd0; ram_wdata = 8'd0; key_we = 1'b0;
        key_waddr = kidx_reg; key_wdata = din_reg;
        s_tready = 1'b0;
        top8 = cnt_reg[7:0];
        draw_v = m_reg & run_reg;
        mod_v = 8'd0;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            csc_pkg::ST_IDLE: begin
                s_tready = !ov_reg;
                if (s_tvalid && !ov_reg) begin
                    kind_next = s_tuser;
                    din_next = s_tdata[7:0];
                    kidx_next = s_tdata[15:8];
                    klen_next = s_tdata[23:16];
                    hcnt_next = hlen_in;
                    cnt_next = 9'd0;
                    case (csc_pkg::kind_t'(s_tuser))
                        csc_pkg::KIND_KEY: state_next = csc_pkg::ST_KEYWR;
                        csc_pkg::KIND_SETUP: begin
                            fmode_next = (s_tdata[23:16] == 8'd0) ? 2'd2 : 2'd1;
                            state_next = csc_pkg::ST_FILL;
                        end
                        csc_pkg::KIND_ENCRYPT, csc_pkg::KIND_DECRYPT: begin
                            hphase_next = 1'b0;
                            state_next = csc_pkg::ST_M_ROT;
                        end
                        csc_pkg::KIND_HASH: begin
                            hphase_next = 1'b0;
                            cnt_next = 9'd255;
                            state_next = csc_pkg::ST_M_ROT;
                        end
                        csc_pkg::KIND_CLEAR: begin
                            fmode_next = 2'd0;
                            rot_next = '0; rat_next = '0; av_next = '0;
                            pp_next = '0; pc_next = '0;
                            state_next = csc_pkg::ST_FILL;
                        end
                        default: state_next = csc_pkg::ST_IDLE;
                    endcase
                end
            end
            csc_pkg::ST_KEYWR: begin
                key_we = 1'b1;
                state_next = csc_pkg::ST_IDLE;
            end
            csc_pkg::ST_FILL: begin
                ram_we = 1'b1;
                ram_addr = cnt_reg[7:0];
                ram_wdata = (fmode_reg == 2'd1) ? cnt_reg[7:0] :
                            (fmode_reg == 2'd2) ? ~cnt_reg[7:0] : 8'd0;
                // zero sweep also wipes the key store
                if (fmode_reg == 2'd0) begin
                    key_we = 1'b1;
                    key_waddr = cnt_reg[7:0];
                    key_wdata = 8'd0;
                end
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd255) begin
                    if (fmode_reg == 2'd2) begin
                        rot_next = 8'd1; rat_next = 8'd3; av_next = 8'd5;
                        pp_next = 8'd7; pc_next = 8'd11;
                        state_next = csc_pkg::ST_IDLE;
                    end else if (fmode_reg == 2'd1) begin
                        cnt_next = 9'd255; run_next = 8'd0; pos_next = 8'd0;
                        m_next = 8'd255; tries_next = 4'd0;
                        state_next = csc_pkg::ST_DR_RD;
                    end else begin
                        state_next = csc_pkg::ST_IDLE;
                    end
                end
            end
            // ---- draw: run = deck[run] + key[pos] ----
            csc_pkg::ST_DR_RD: begin
                ram_addr = run_reg;
                rd_next = 1'b1;
                if (cnt_reg[7:0] == 8'd0) begin
                    rd_next = 1'b0;
                    sel_next = 8'd0;
                    state_next = csc_pkg::ST_SW_RDI;
                end else if (rd_reg) begin
                    rd_next = 1'b0;
                    t_next = ram_rdata;
                    state_next = csc_pkg::ST_DR_KEY;
                end
            end
            csc_pkg::ST_DR_KEY: begin
                rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0;
                    run_next = t_reg + key_rd;
                    if ({1'b0, pos_reg} + 9'd1 >= {1'b0, klen_reg}) begin
                        pos_next = 8'd0;
                        run_next = t_reg + key_rd + klen_reg;
                    end else begin
                        pos_next = pos_reg + 8'd1;
                    end
                    tries_next = tries_reg + 4'd1;
                    state_next = csc_pkg::ST_DR_CHK;
                end
            end
            csc_pkg::ST_DR_CHK: begin
                // modulo via repeated subtract (value < 256, top >= 1)
                if (tries_reg > 4'd11 && draw_v >= top8 && rd_reg == 1'b0) begin
                    m_next = m_reg;
                    run_next = run_reg;
                    x_next = draw_v - top8;
                    rd_next = 1'b1;
                    // iterate in x
                    state_next = csc_pkg::ST_DR_CHK;
                end else if (rd_reg) begin
                    if (x_reg >= top8) begin
                        x_next = x_reg - top8;
                        rd_next = 1'b1;
                    end else begin
                        sel_next = x_reg;
                        state_next = csc_pkg::ST_SW_RDI;
                    end
                end else begin
                    mod_v = draw_v;
                    if (mod_v > top8) begin
                        state_next = csc_pkg::ST_DR_RD;
                    end else begin
                        sel_next = mod_v;
                        state_next = csc_pkg::ST_SW_RDI;
                    end
                end
            end
            csc_pkg::ST_SW_RDI: begin
                ram_addr = cnt_reg[7:0];
                rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0;
                    t_next = ram_rdata;
                    state_next = csc_pkg::ST_SW_RDS;
                end
            end
            csc_pkg::ST_SW_RDS: begin
                ram_addr = sel_reg;
                rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0;
                    u_next = ram_rdata;
                    state_next = csc_pkg::ST_SW_WRI;
                end
            end
            csc_pkg::ST_SW_WRI: begin
                ram_we = 1'b1; ram_addr = cnt_reg[7:0]; ram_wdata = u_reg;
                state_next = csc_pkg::ST_SW_WRS;
            end
            csc_pkg::ST_SW_WRS: begin
                ram_we = 1'b1; ram_addr = sel_reg; ram_wdata = t_reg;
                tries_next = 4'd0;
                if (cnt_reg[7:0] == 8'd0) begin
                    state_next = csc_pkg::ST_SD_1;
                end else begin
                    cnt_next = cnt_reg - 9'd1;
                    // next mask: smallest 2^k-1 >= top-1
                    if ({1'b0, m_reg[7:1]} >= cnt_reg[7:0] - 8'd1 && m_reg != 8'd1) begin
                        m_next = {1'b0, m_reg[7:1]};
                    end
                    state_next = csc_pkg::ST_DR_RD;
                end
            end
            csc_pkg::ST_SD_1, csc_pkg::ST_SD_3, csc_pkg::ST_SD_5,
            csc_pkg::ST_SD_7, csc_pkg::ST_SD_R: begin
                rd_next = 1'b1;
                case (state_reg)
                    csc_pkg::ST_SD_1: ram_addr = 8'd1;
                    csc_pkg::ST_SD_3: ram_addr = 8'd3;
                    csc_pkg::ST_SD_5: ram_addr = 8'd5;
                    csc_pkg::ST_SD_7: ram_addr = 8'd7;
                    default:          ram_addr = run_reg;
                endcase
                if (rd_reg) begin
                    rd_next = 1'b0;
                    case (state_reg)
                        csc_pkg::ST_SD_1: begin
                            rot_next = ram_rdata; state_next = csc_pkg::ST_SD_3;
                        end
                        csc_pkg::ST_SD_3: begin
                            rat_next = ram_rdata; state_next = csc_pkg::ST_SD_5;
                        end
                        csc_pkg::ST_SD_5: begin
                            av_next = ram_rdata; state_next = csc_pkg::ST_SD_7;
                        end
                        csc_pkg::ST_SD_7: begin
                            pp_next = ram_rdata; state_next = csc_pkg::ST_SD_R;
                        end
                        default: begin
                            pc_next = ram_rdata; state_next = csc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            // ---- shuffle / mask ----
            csc_pkg::ST_M_ROT: begin
                ram_addr = rot_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0;
                    rat_next = rat_reg + ram_rdata;
                    rot_next = rot_reg + 8'd1;
                    state_next = csc_pkg::ST_M_PC;
                end
            end
            csc_pkg::ST_M_PC: begin
                ram_addr = pc_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; t_next = ram_rdata; state_next = csc_pkg::ST_M_RA;
                end
            end
            csc_pkg::ST_M_RA: begin
                ram_addr = rat_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; a_next = ram_rdata; state_next = csc_pkg::ST_M_W1;
                end
            end
            csc_pkg::ST_M_W1: begin
                ram_we = 1'b1; ram_addr = pc_reg; ram_wdata = a_reg;
                state_next = csc_pkg::ST_M_PP;
            end
            csc_pkg::ST_M_PP: begin
                ram_addr = pp_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; a_next = ram_rdata; state_next = csc_pkg::ST_M_W2;
                end
            end
            csc_pkg::ST_M_W2: begin
                ram_we = 1'b1; ram_addr = rat_reg; ram_wdata = a_reg;
                state_next = csc_pkg::ST_M_RO;
            end
            csc_pkg::ST_M_RO: begin
                ram_addr = rot_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; a_next = ram_rdata; state_next = csc_pkg::ST_M_W3;
                end
            end
            csc_pkg::ST_M_W3: begin
                ram_we = 1'b1; ram_addr = pp_reg; ram_wdata = a_reg;
                state_next = csc_pkg::ST_M_W4;
            end
            csc_pkg::ST_M_W4: begin
                ram_we = 1'b1; ram_addr = rot_reg; ram_wdata = t_reg;
                state_next = csc_pkg::ST_M_T;
            end
            csc_pkg::ST_M_T: begin
                ram_addr = t_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; av_next = av_reg + ram_rdata;
                    state_next = csc_pkg::ST_M_AV;
                end
            end
            csc_pkg::ST_M_AV: begin
                ram_addr = av_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; x_next = ram_rdata; state_next = csc_pkg::ST_M_RO2;
                end
            end
            csc_pkg::ST_M_RO2: begin
                ram_addr = rot_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; x_next = x_reg + ram_rdata;
                    state_next = csc_pkg::ST_M_A;
                end
            end
            csc_pkg::ST_M_A: begin
                ram_addr = x_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; a_next = ram_rdata; state_next = csc_pkg::ST_M_X1;
                end
            end
            csc_pkg::ST_M_X1: begin
                ram_addr = pp_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; x_next = ram_rdata; state_next = csc_pkg::ST_M_X2;
                end
            end
            csc_pkg::ST_M_X2: begin
                ram_addr = pc_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; x_next = x_reg + ram_rdata;
                    state_next = csc_pkg::ST_M_X3;
                end
            end
            csc_pkg::ST_M_X3: begin
                ram_addr = rat_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; x_next = x_reg + ram_rdata;
                    state_next = csc_pkg::ST_M_B1;
                end
            end
            csc_pkg::ST_M_B1: begin
                ram_addr = x_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; x_next = ram_rdata; state_next = csc_pkg::ST_M_B2;
                end
            end
            csc_pkg::ST_M_B2: begin
                ram_addr = x_reg; rd_next = 1'b1;
                if (rd_reg) begin
                    rd_next = 1'b0; b_next = ram_rdata; state_next = csc_pkg::ST_M_FIN;
                end
            end
            csc_pkg::ST_M_FIN: begin
                // plain and cipher for this byte
                if (kind_reg == csc_pkg::KIND_DECRYPT) begin
                    ct_next = din_reg;
                    pt_next = din_reg ^ a_reg ^ b_reg;
                    od_next = din_reg ^ a_reg ^ b_reg;
                    state_next = csc_pkg::ST_OUT;
                    ol_next = 1'b1;
                end else if (kind_reg == csc_pkg::KIND_ENCRYPT) begin
                    pt_next = din_reg;
                    ct_next = din_reg ^ a_reg ^ b_reg;
                    od_next = din_reg ^ a_reg ^ b_reg;
                    state_next = csc_pkg::ST_OUT;
                    ol_next = 1'b1;
                end else if (!hphase_reg) begin
                    pt_next = cnt_reg[7:0];
                    ct_next = cnt_reg[7:0] ^ a_reg ^ b_reg;
                    state_next = csc_pkg::ST_OUT;
                end else begin
                    // hash byte: output register loads in ST_OUT once it is free
                    pt_next = 8'd0;
                    ct_next = a_reg ^ b_reg;
                    state_next = csc_pkg::ST_OUT;
                end
            end
            csc_pkg::ST_OUT: begin
                pp_next = pt_reg; pc_next = ct_reg;
                state_next = csc_pkg::ST_IDLE;
                if (kind_reg == csc_pkg::KIND_HASH) begin
                    if (!hphase_reg) begin
                        if (cnt_reg == 9'd0) begin
                            hphase_next = 1'b1;
                            if (hcnt_reg != '0) begin
                                state_next = csc_pkg::ST_M_ROT;
                            end
                        end else begin
                            cnt_next = cnt_reg - 9'd1;
                            state_next = csc_pkg::ST_M_ROT;
                        end
                    end else if (!ov_reg || m_tready) begin
                        ov_next = 1'b1;
                        od_next = ct_reg;
                        ol_next = (hcnt_reg == HW'(1));
                        hcnt_next = hcnt_reg - HW'(1);
                        if (hcnt_reg != HW'(1)) begin
                            state_next = csc_pkg::ST_M_ROT;
                        end
                    end else begin
                        pp_next = pp_reg; pc_next = pc_reg;
                        state_next = csc_pkg::ST_OUT;
                    end
                end else if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                end else begin
                    state_next = csc_pkg::ST_OUT;
                end
            end
            default: state_next = csc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // zero sweep of the deck after reset
            state_reg <= csc_pkg::ST_FILL;
            fmode_reg <= 2'd0;
            cnt_reg <= 9'd0;
            ov_reg <= 1'b0;
            rd_reg <= 1'b0;
            hphase_reg <= 1'b0;
            kind_reg <= 3'd0;
            rot_reg <= '0; rat_reg <= '0; av_reg <= '0; pp_reg <= '0; pc_reg <= '0;
        end else begin
            state_reg <= state_next; fmode_reg <= fmode_next; cnt_reg <= cnt_next;
            ov_reg <= ov_next; rd_reg <= rd_next; hphase_reg <= hphase_next;
            kind_reg <= kind_next;
            rot_reg <= rot_next; rat_reg <= rat_next; av_reg <= av_next;
            pp_reg <= pp_next; pc_reg <= pc_next;
        end
        din_reg <= din_next; kidx_reg <= kidx_next; klen_reg <= klen_next;
        hcnt_reg <= hcnt_next; run_reg <= run_next; pos_reg <= pos_next;
        m_reg <= m_next; tries_reg <= tries_next; sel_reg <= sel_next;
        t_reg <= t_next; u_reg <= u_next; x_reg <= x_next; a_reg <= a_next;
        b_reg <= b_next; ct_reg <= ct_next; pt_reg <= pt_next;
        od_reg <= od_next; ol_reg <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

    `CHK_IMPL(a_ready_idle, aclk, aresetn, s_tready, state_reg == csc_pkg::ST_IDLE && !ov_reg)
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CHK_IMPL(a_no_write_idle, aclk, aresetn, state_reg == csc_pkg::ST_IDLE, !ram_we)
endmodule
`default_nettype wire

FILE: sv/csc_deck_ram.sv
// Single-port 256 x 8 deck store with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module csc_deck_ram (
    input  wire logic       aclk,
    input  wire logic       we,
    input  wire logic [7:0] addr,
    input  wire logic [7:0] wdata,
    output logic      [7:0] rdata
);
    logic [7:0] mem [256];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
